@@ rtl/bll_pkg.sv @@
// Package with shared types, constants and codes of the linked list engine.
`timescale 1ns / 1ps
package bll_pkg;
    localparam int CAPACITY = 64;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = 7;

    typedef enum logic [3:0] {
        REQ_INS_HEAD = 4'd0,
        REQ_INS_TAIL = 4'd1,
        REQ_INS_POS  = 4'd2,
        REQ_UPDATE   = 4'd3,
        REQ_DEL_HEAD = 4'd4,
        REQ_DEL_TAIL = 4'd5,
        REQ_DEL_POS  = 4'd6,
        REQ_COUNT    = 4'd7,
        REQ_DISPLAY  = 4'd8
    } t_req;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADPOS   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [3:0]        req_type;
        logic signed [31:0] value;
        logic signed [31:0] new_value;
        logic [6:0]        position;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item_value;
        logic [6:0]         count;
        logic               last;
    } t_out;
endpackage

@@ rtl/bll_if.sv @@
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps
interface bll_in_if;
    logic          valid;
    logic          ready;
    bll_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bll_out_if;
    logic          valid;
    logic          ready;
    bll_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bll_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/bounded_linked_list_engine.sv @@
// A request walks the list one node at a time (address, then data); display gives one
// result per node, and the next item is taken only once the last result is accepted.
// One request is handled at a time; the walk through the node memory sets the rate.
// Reset (synchronous, active low) empties the list and refills the free stack
// by a counter, so no clearing pass is needed.
`timescale 1ns / 1ps
module bounded_linked_list_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bll_in_if.sink     i_req,
    bll_out_if.source  o_res
);
    localparam int IW = bll_pkg::IDX_W;
    localparam int CW = bll_pkg::CNT_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FREE  = 8'b0000_0010,
        S_WALK  = 8'b0000_0100,
        S_WAIT  = 8'b0000_1000,
        S_LINK  = 8'b0001_0000,
        S_VICT  = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    bll_pkg::t_in  r_req;
    bll_pkg::t_out r_out;
    logic          r_ovalid;

    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ftop;
    // Free stack entries below r_fill have never been written and hold their own index.
    logic [CW-1:0] r_fill;
    logic [IW-1:0] r_cur;
    logic [CW-1:0] r_step;
    logic [CW-1:0] r_target;
    logic [IW-1:0] r_newn;
    logic [IW-1:0] r_prev;

    // Memories
    logic          val_we, lnk_we, fs_we;
    logic [IW-1:0] val_wa, lnk_wa, fs_wa, val_ra, lnk_ra, fs_ra;
    logic [31:0]   val_wd, val_rd;
    logic [IW-1:0] lnk_wd, lnk_rd, fs_wd, fs_rd;
    logic [IW-1:0] fs_q;

    bll_ram #(.WIDTH(32), .DEPTH(bll_pkg::CAPACITY)) u_val (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_wa), .i_wdata(val_wd),
        .i_raddr(val_ra), .o_rdata(val_rd));
    bll_ram #(.WIDTH(IW), .DEPTH(bll_pkg::CAPACITY)) u_lnk (
        .i_clk(i_clk), .i_we(lnk_we), .i_waddr(lnk_wa), .i_wdata(lnk_wd),
        .i_raddr(lnk_ra), .o_rdata(lnk_rd));
    bll_ram #(.WIDTH(IW), .DEPTH(bll_pkg::CAPACITY)) u_fs (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_wa), .i_wdata(fs_wd),
        .i_raddr(fs_ra), .o_rdata(fs_rd));

    logic [CW-1:0] r_fsaddr;
    assign fs_q = (r_fsaddr < r_fill) ? r_fsaddr[IW-1:0] : fs_rd;

    logic acc, oacc, full, ins, del;
    logic [CW-1:0] tgt;
    assign acc  = i_req.valid && i_req.ready;
    assign oacc = o_res.valid && o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;
    assign full = (r_count >= CW'(bll_pkg::CAPACITY)) || (r_ftop == '0);
    assign ins = (r_req.req_type == bll_pkg::REQ_INS_HEAD) ||
                 (r_req.req_type == bll_pkg::REQ_INS_TAIL) ||
                 (r_req.req_type == bll_pkg::REQ_INS_POS);
    assign del = (r_req.req_type == bll_pkg::REQ_DEL_HEAD) ||
                 (r_req.req_type == bll_pkg::REQ_DEL_TAIL) ||
                 (r_req.req_type == bll_pkg::REQ_DEL_POS);

    // Memory addressing: reads go to r_cur; the wait state S_WAIT brings the data.
    // The free stack top is read all the time, so its entry is ready in S_FREE.
    always_comb begin
        val_ra = r_cur;
        lnk_ra = r_cur;
        fs_ra  = IW'(r_ftop - CW'(1));
        val_we = 1'b0; val_wa = r_newn; val_wd = r_req.value;
        lnk_we = 1'b0; lnk_wa = r_newn; lnk_wd = '0;
        fs_we  = 1'b0; fs_wa = r_ftop[IW-1:0]; fs_wd = r_cur;
        if (r_state == S_LINK) begin
            if (ins) begin
                val_we = 1'b1;
                lnk_we = 1'b1;
                lnk_wa = r_newn;
                lnk_wd = (r_target == CW'(1)) ? r_head : lnk_rd;
            end
        end else if (r_state == S_VICT) begin
            if (ins) begin
                // r_cur is the predecessor; it now points to the new node.
                lnk_we = 1'b1;
                lnk_wa = r_cur;
                lnk_wd = r_newn;
            end else begin
                // r_cur is the victim, lnk_rd its successor.
                if (r_target != CW'(1)) begin
                    lnk_we = 1'b1;
                    lnk_wa = r_prev;
                    lnk_wd = lnk_rd;
                end
                fs_we = (r_ftop < CW'(bll_pkg::CAPACITY));
            end
        end else if (r_state == S_EMIT && r_req.req_type == bll_pkg::REQ_UPDATE
                     && val_rd == r_req.value) begin
            val_we = 1'b1;
            val_wa = r_cur;
            val_wd = r_req.new_value;
        end
    end

    always_comb begin
        unique case (i_req.data.req_type)
            bll_pkg::REQ_INS_TAIL: tgt = r_count + CW'(1);
            bll_pkg::REQ_DEL_TAIL: tgt = r_count;
            default:               tgt = i_req.data.position;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
            r_ftop   <= CW'(bll_pkg::CAPACITY);
            r_fill   <= CW'(bll_pkg::CAPACITY);
        end else begin
            if (oacc) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_req    <= i_req.data;
                        r_target <= (i_req.data.req_type == bll_pkg::REQ_INS_HEAD ||
                                     i_req.data.req_type == bll_pkg::REQ_DEL_HEAD)
                                    ? CW'(1) : tgt;
                        r_cur    <= r_head;
                        r_prev   <= r_head;
                        r_step   <= CW'(1);
                        r_fsaddr <= r_ftop - CW'(1);
                        r_out.status     <= bll_pkg::ST_OK;
                        r_out.item_value <= '0;
                        r_out.last       <= 1'b1;
                        r_out.count      <= r_count;
                        r_state <= S_OUT;
                        unique case (i_req.data.req_type) inside
                            bll_pkg::REQ_INS_HEAD, bll_pkg::REQ_INS_TAIL,
                            bll_pkg::REQ_INS_POS: begin
                                if (i_req.data.req_type == bll_pkg::REQ_INS_POS &&
                                    (i_req.data.position == '0 ||
                                     i_req.data.position > r_count + CW'(1)))
                                    r_out.status <= bll_pkg::ST_BADPOS;
                                else if (full)
                                    r_out.status <= bll_pkg::ST_FULL;
                                else
                                    r_state <= S_FREE;
                            end
                            bll_pkg::REQ_DEL_HEAD, bll_pkg::REQ_DEL_TAIL: begin
                                if (r_count == '0) r_out.status <= bll_pkg::ST_EMPTY;
                                else r_state <= S_WAIT;
                            end
                            bll_pkg::REQ_DEL_POS: begin
                                if (i_req.data.position == '0 ||
                                    i_req.data.position > r_count)
                                    r_out.status <= bll_pkg::ST_BADPOS;
                                else r_state <= S_WAIT;
                            end
                            bll_pkg::REQ_UPDATE: begin
                                r_out.status <= bll_pkg::ST_NOTFOUND;
                                if (r_count != '0) r_state <= S_WAIT;
                            end
                            bll_pkg::REQ_DISPLAY: begin
                                if (r_count == '0) r_out.status <= bll_pkg::ST_EMPTY;
                                else r_state <= S_WAIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FREE: begin
                    // Free stack read data is valid now.
                    r_newn <= fs_q;
                    r_ftop <= r_ftop - CW'(1);
                    if (r_fsaddr < r_fill) r_fill <= r_fsaddr;
                    r_state <= S_WAIT;
                    if (r_target <= CW'(2)) r_step <= r_target;
                end
                S_WAIT: r_state <= (del && r_step == r_target) ? S_VICT
                                   : ((ins || del) && r_step >= r_target - CW'(1)) ? S_LINK
                                   : (ins || del) ? S_WALK : S_EMIT;
                S_WALK: begin
                    // Step to the next node; r_prev follows one behind.
                    r_prev <= r_cur;
                    r_cur  <= lnk_rd;
                    r_step <= r_step + CW'(1);
                    r_state <= S_WAIT;
                end
                S_LINK: begin
                    if (ins) begin
                        if (r_target == CW'(1)) begin
                            r_head <= r_newn;
                            r_count <= r_count + CW'(1);
                            r_out.count <= r_count + CW'(1);
                            r_state <= S_OUT;
                        end else begin
                            // The predecessor's link is written in the next cycle.
                            r_state <= S_VICT;
                        end
                    end else begin
                        // Predecessor found; read the victim next.
                        r_prev <= r_cur;
                        r_cur  <= lnk_rd;
                        r_step <= r_target;
                        r_state <= S_WAIT;
                    end
                end
                S_VICT: begin
                    if (ins) begin
                        r_count <= r_count + CW'(1);
                        r_out.count <= r_count + CW'(1);
                    end else begin
                        if (r_target == CW'(1)) r_head <= lnk_rd;
                        if (r_ftop < CW'(bll_pkg::CAPACITY)) r_ftop <= r_ftop + CW'(1);
                        r_count <= r_count - CW'(1);
                        r_out.count <= r_count - CW'(1);
                    end
                    r_state <= S_OUT;
                end
                S_EMIT: begin
                    if (r_req.req_type == bll_pkg::REQ_UPDATE) begin
                        if (val_rd == r_req.value) begin
                            r_out.status <= bll_pkg::ST_OK;
                            r_state <= S_OUT;
                        end else if (r_step == r_count) begin
                            r_state <= S_OUT;
                        end else begin
                            r_cur <= lnk_rd;
                            r_step <= r_step + CW'(1);
                            r_state <= S_WAIT;
                        end
                    end else if (!r_ovalid) begin
                        r_out.item_value <= val_rd;
                        r_out.last <= (r_step == r_count);
                        r_ovalid <= 1'b1;
                        r_cur <= lnk_rd;
                        r_step <= r_step + CW'(1);
                        r_state <= (r_step == r_count) ? S_IDLE : S_WAIT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/bll_checker.sv @@
// Port-level checker for the linked list engine, bound to the top level.
`timescale 1ns / 1ps
module bll_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input bll_pkg::t_out out_data
);
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data.count <= 7'(bll_pkg::CAPACITY)) else $error("count range");
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data.status <= bll_pkg::ST_FULL) else $error("bad status");
    a_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.status != bll_pkg::ST_OK |-> out_data.last
        && out_data.item_value == 0) else $error("error result not final");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
    // Once an item is taken the engine is busy and has no result yet.
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid) else $error("request not taken");
endmodule

bind bounded_linked_list_engine bll_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_req.valid), .in_ready(i_req.ready),
    .out_valid(o_res.valid), .out_ready(o_res.ready), .out_data(o_res.data));

@@ verif/tb_bounded_linked_list_engine.sv @@
// Self-checking testbench of the bounded linked list engine with a list predictor.
`timescale 1ns / 1ps
module tb_bounded_linked_list_engine;
    localparam int RAND_ITEMS = 324;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;

    bll_in_if  req_ch ();
    bll_out_if res_ch ();

    bounded_linked_list_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Predicted list contents, head first, and the results still to arrive.
    logic signed [31:0]    list_vals[$];
    bll_pkg::t_out         expected_res[$];
    bll_pkg::t_in          pending_req[$];
    int                    fail_cnt = 0;
    int                    cycle_cnt = 0;
    bit                    stim_done = 1'b0;
    // Set at the rising edge at which an item was taken on each channel.
    bit                    req_fire = 1'b0;
    bit                    res_fire = 1'b0;

    function automatic bll_pkg::t_out mk_res(logic [2:0] st, logic signed [31:0] v,
                                             logic lst);
        bll_pkg::t_out r;
        r.status = st;
        r.item_value = v;
        r.count = 7'(list_vals.size());
        r.last = lst;
        return r;
    endfunction

    task automatic predict_list(input bll_pkg::t_in rq);
        int n;
        logic [2:0] st;
        n = list_vals.size();
        st = bll_pkg::ST_OK;
        case (rq.req_type)
            bll_pkg::REQ_INS_HEAD:
                if (n >= bll_pkg::CAPACITY) st = bll_pkg::ST_FULL;
                else list_vals.push_front(rq.value);
            bll_pkg::REQ_INS_TAIL:
                if (n >= bll_pkg::CAPACITY) st = bll_pkg::ST_FULL;
                else list_vals.push_back(rq.value);
            bll_pkg::REQ_INS_POS: begin
                if (rq.position < 1 || rq.position > n + 1) st = bll_pkg::ST_BADPOS;
                else if (n >= bll_pkg::CAPACITY) st = bll_pkg::ST_FULL;
                else list_vals.insert(rq.position - 1, rq.value);
            end
            bll_pkg::REQ_UPDATE: begin
                st = bll_pkg::ST_NOTFOUND;
                foreach (list_vals[i]) begin
                    if (st == bll_pkg::ST_NOTFOUND && list_vals[i] == rq.value) begin
                        list_vals[i] = rq.new_value;
                        st = bll_pkg::ST_OK;
                    end
                end
            end
            bll_pkg::REQ_DEL_HEAD:
                if (n == 0) st = bll_pkg::ST_EMPTY; else void'(list_vals.pop_front());
            bll_pkg::REQ_DEL_TAIL:
                if (n == 0) st = bll_pkg::ST_EMPTY; else void'(list_vals.pop_back());
            bll_pkg::REQ_DEL_POS: begin
                if (rq.position < 1 || rq.position > n) st = bll_pkg::ST_BADPOS;
                else list_vals.delete(rq.position - 1);
            end
            bll_pkg::REQ_DISPLAY: begin
                if (n == 0) st = bll_pkg::ST_EMPTY;
                else begin
                    foreach (list_vals[i])
                        expected_res.push_back(mk_res(bll_pkg::ST_OK, list_vals[i],
                                                      i == n - 1));
                    return;
                end
            end
            default: ;
        endcase
        expected_res.push_back(mk_res(st, 32'sd0, 1'b1));
    endtask

    function automatic bll_pkg::t_in mk_req(bll_pkg::t_req kind, logic signed [31:0] v,
                                            logic signed [31:0] nv, logic [6:0] pos);
        bll_pkg::t_in r;
        r.req_type = kind;
        r.value = v;
        r.new_value = nv;
        r.position = pos;
        return r;
    endfunction

    // Values drawn mostly from a small set so that updates find matches.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 32'(signed'($urandom()));
            1: return 32'sh8000_0000;
            2: return 32'sh7FFF_FFFF;
            default: return 32'($urandom_range(0, 7)) - 32'sd3;
        endcase
    endfunction

    function automatic bll_pkg::t_in rand_req();
        bll_pkg::t_in r;
        int w;
        w = $urandom_range(0, 99);
        r.value = pick_value();
        r.new_value = pick_value();
        r.position = 7'($urandom_range(0, 66));
        if (w < 3) r.position = 7'($urandom_range(0, 127));
        if (w < 22) r.req_type = bll_pkg::REQ_INS_TAIL;
        else if (w < 36) r.req_type = bll_pkg::REQ_INS_HEAD;
        else if (w < 50) r.req_type = bll_pkg::REQ_INS_POS;
        else if (w < 60) r.req_type = bll_pkg::REQ_UPDATE;
        else if (w < 67) r.req_type = bll_pkg::REQ_DEL_HEAD;
        else if (w < 74) r.req_type = bll_pkg::REQ_DEL_TAIL;
        else if (w < 84) r.req_type = bll_pkg::REQ_DEL_POS;
        else if (w < 89) r.req_type = bll_pkg::REQ_COUNT;
        else if (w < 97) r.req_type = bll_pkg::REQ_DISPLAY;
        else r.req_type = 4'($urandom_range(9, 15));
        return r;
    endfunction

    initial begin
        // Empty-list cases first, then extremes of each field.
        pending_req.push_back(mk_req(bll_pkg::REQ_DISPLAY, 0, 0, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_DEL_HEAD, 0, 0, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_DEL_TAIL, 0, 0, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_DEL_POS, 0, 0, 1));
        pending_req.push_back(mk_req(bll_pkg::REQ_UPDATE, 5, 6, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_INS_POS, 1, 0, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_INS_POS, 1, 0, 2));
        pending_req.push_back(mk_req(bll_pkg::REQ_INS_HEAD, 32'sh8000_0000, 0, 7'h7F));
        pending_req.push_back(mk_req(bll_pkg::REQ_INS_TAIL, 32'sh7FFF_FFFF, -1, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_INS_POS, -1, 0, 2));
        pending_req.push_back(mk_req(bll_pkg::REQ_INS_POS, 7, 0, 4));
        pending_req.push_back(mk_req(bll_pkg::REQ_INS_POS, 7, 0, 5));
        pending_req.push_back(mk_req(bll_pkg::REQ_UPDATE, 7, 32'sh7FFF_FFFF, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_UPDATE, -1, 32'sh8000_0000, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_DISPLAY, 0, 0, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_COUNT, -1, -1, 7'h7F));
        pending_req.push_back(mk_req(bll_pkg::REQ_DEL_POS, 0, 0, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_DEL_POS, 0, 0, 5));
        pending_req.push_back(mk_req(bll_pkg::REQ_DEL_POS, 0, 0, 2));
        pending_req.push_back(mk_req(bll_pkg::REQ_DEL_TAIL, 0, 0, 0));
        pending_req.push_back(bll_pkg::t_in'({4'hF, 32'sh7FFF_FFFF, 32'sh8000_0000, 7'h7F}));
        // Fill the pool to capacity, hit the full cases, then drain it again.
        for (int i = 0; i < bll_pkg::CAPACITY; i++)
            pending_req.push_back(mk_req(bll_pkg::REQ_INS_TAIL, 32'(i * 3), 0, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_INS_HEAD, 1, 0, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_INS_TAIL, 1, 0, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_INS_POS, 1, 0, 65));
        pending_req.push_back(mk_req(bll_pkg::REQ_INS_POS, 1, 0, 66));
        pending_req.push_back(mk_req(bll_pkg::REQ_UPDATE, 189, 4, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_DISPLAY, 0, 0, 0));
        pending_req.push_back(mk_req(bll_pkg::REQ_DEL_POS, 0, 0, 64));
        pending_req.push_back(mk_req(bll_pkg::REQ_DEL_POS, 0, 0, 64));
        for (int i = 0; i < bll_pkg::CAPACITY - 1; i++)
            pending_req.push_back(mk_req(bll_pkg::REQ_DEL_HEAD, 0, 0, 0));
        for (int i = 0; i < RAND_ITEMS; i++)
            pending_req.push_back(rand_req());
    end

    // Request driver: random gap before each item, inputs change on the falling edge.
    int req_gap = 0;
    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        res_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_fire) begin
                req_ch.valid <= 1'b0;
                req_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
            end else if (!req_ch.valid) begin
                if (req_gap > 0) begin
                    req_gap <= req_gap - 1;
                end else if (pending_req.size() > 0) begin
                    req_ch.data <= pending_req.pop_front();
                    req_ch.valid <= 1'b1;
                end else begin
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // Result sink: stalls drawn per item.
    int res_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (res_fire) begin
                res_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
                res_ch.ready <= (res_gap == 0);
            end else if (res_gap > 0) begin
                res_gap = res_gap - 1;
                res_ch.ready <= (res_gap == 0);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: accept on the rising edge, predict requests and check results.
    always @(posedge i_clk) begin
        bll_pkg::t_out want;
        cycle_cnt <= cycle_cnt + 1;
        req_fire <= i_rst_n && req_ch.valid && req_ch.ready;
        res_fire <= i_rst_n && res_ch.valid && res_ch.ready;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                predict_list(req_ch.data);
            if (res_ch.valid && res_ch.ready) begin
                if (expected_res.size() == 0) begin
                    $error("unexpected result: status %0d item_value %0d count %0d last %0d",
                           res_ch.data.status, res_ch.data.item_value,
                           res_ch.data.count, res_ch.data.last);
                    fail_cnt++;
                end else begin
                    want = expected_res.pop_front();
                    if (res_ch.data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_ch.data.status);
                        fail_cnt++;
                    end
                    if (res_ch.data.item_value !== want.item_value) begin
                        $error("item_value: expected %0d, got %0d",
                               want.item_value, res_ch.data.item_value);
                        fail_cnt++;
                    end
                    if (res_ch.data.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, res_ch.data.count);
                        fail_cnt++;
                    end
                    if (res_ch.data.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, res_ch.data.last);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        int settle;
        settle = 0;
        while (!(stim_done && expected_res.size() == 0) && cycle_cnt < CYCLE_LIMIT)
            @(posedge i_clk);
        // Allow a full walk of the pool for any stray result to show up.
        while (settle < 4 * bll_pkg::CAPACITY + 20 && cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            settle++;
        end
        #0.5;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** bounded_linked_list_engine: FAILED **");
        end else if (fail_cnt == 0 && expected_res.size() == 0) begin
            $display("** bounded_linked_list_engine: PASSED **");
        end else begin
            $display("** bounded_linked_list_engine: FAILED **");
        end
        $finish;
    end
endmodule
